/* rtl/core/ffsca_pkg.sv */
package ffsca_pkg;

  // payload widths
  localparam int SIZE_W  = 15;
  localparam int GRAN_W  = 10;
  localparam int STAT_W  = 2;
  localparam int SPLIT_W = 7;
  localparam int NEED_W  = 13;

  // granule geometry: 16 bytes
  localparam int GRANULE_SHIFT = 4;
  localparam logic [SIZE_W:0] GRANULE_MASK = (SIZE_W+1)'(15);

  localparam logic [SPLIT_W-1:0] SPLIT_RESET = SPLIT_W'(4);

  // request codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // result codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO    = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOFIT   = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTUSED = 2'd3;

endpackage

/* rtl/core/first_fit_split_coalesce_allocator.sv */
// channel  | handshake                | fields
// ---------+--------------------------+--------------------------------------
// in       | in_valid / in_ready      | action, size_bytes, payload_granule
// out      | out_valid / out_ready    | status, granted_granule
// cfg      | cfg_wr_en                | cfg_wr_data (min_split_granules)
//
// allocate: a first-fit walk over the chunks, plus a split step when the chosen chunk is split;
//   the walk reads one chunk header word per cycle from the chunk memory.
// free: dependent reads of next, previous-link and previous chunk, merging with free neighbours.
// reset runs a clearing pass over the chunk memory; in_ready is low.
// one item is in work at a time; a finished result waits in the output register
//   while the next item is accepted.
module first_fit_split_coalesce_allocator
  import ffsca_pkg::*;
#(
  parameter int ARENA_GRANULES  = 1024,
  parameter int HEADER_GRANULES = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                action,
  input  logic [SIZE_W-1:0]   size_bytes,
  input  logic [GRAN_W-1:0]   payload_granule,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STAT_W-1:0]   status,
  output logic [GRAN_W-1:0]   granted_granule,
  input  logic                cfg_wr_en,
  input  logic [SPLIT_W-1:0]  cfg_wr_data
);

  localparam int AW = $clog2(ARENA_GRANULES);
  localparam int LW = AW + 1;
  localparam int CW = ((LW > NEED_W) ? LW : NEED_W) + 1;
  localparam logic [LW-1:0] ARENA_LEN = LW'(ARENA_GRANULES);
  localparam logic [AW-1:0] CLR_LAST = AW'(ARENA_GRANULES - 1);

  typedef struct packed {
    logic [LW-1:0] len;
    logic          used;
    logic          mark;
  } word_t;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_A_CHK = 11'b00000000100,
    S_A_SPL = 11'b00000001000,
    S_F_CHK = 11'b00000010000,
    S_F_NXT = 11'b00000100000,
    S_F_PR0 = 11'b00001000000,
    S_F_PR1 = 11'b00010000000,
    S_F_PR2 = 11'b00100000000,
    S_F_MRG = 11'b01000000000,
    S_RESP  = 11'b10000000000
  } st_t;

  st_t st, st_next;
  logic [AW-1:0]     at, at_next, prv, prv_next, clr;
  logic [LW-1:0]     len_cur, len_cur_next;
  logic [NEED_W-1:0] need, need_next;
  logic [SPLIT_W-1:0] min_split;
  logic [STAT_W-1:0] res_status, res_status_next;
  logic [GRAN_W-1:0] res_gran, res_gran_next;

  // chunk memory and previous-link memory
  word_t         amem [ARENA_GRANULES];
  logic [AW-1:0] pmem [ARENA_GRANULES];
  word_t         a_q, a_wdata;
  logic [AW-1:0] p_q, p_wdata, a_waddr, a_raddr, p_waddr, p_raddr;
  logic          a_we, p_we;

  always_ff @(posedge clk) begin
    if (a_we) begin
      amem[a_waddr] <= a_wdata;
    end
    a_q <= amem[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      pmem[p_waddr] <= p_wdata;
    end
    p_q <= pmem[p_raddr];
  end

  // request decode
  logic [SIZE_W:0]   sz_round;
  logic [NEED_W-1:0] need_calc;
  logic [GRAN_W-1:0] pay_off;
  logic              pay_bad;
  logic [SPLIT_W-1:0] split_eff;

  assign sz_round  = {1'b0, size_bytes} + GRANULE_MASK;
  assign need_calc = NEED_W'(sz_round >> GRANULE_SHIFT) + NEED_W'(HEADER_GRANULES);
  assign pay_off   = payload_granule - GRAN_W'(HEADER_GRANULES);
  assign pay_bad   = (32'(payload_granule) < 32'(HEADER_GRANULES))
                     || (32'(pay_off) >= 32'(ARENA_GRANULES));
  assign split_eff = (min_split == '0) ? SPLIT_W'(1) : min_split;

  // chunk arithmetic on the word just read
  logic [LW-1:0] at_ext, at_plus_q, at_plus_cur, nxt_plus_q, at_gran;
  logic          len_ge_need, len_ge_split;

  assign at_ext      = {1'b0, at};
  assign at_plus_q   = at_ext + a_q.len;
  assign at_plus_cur = at_ext + len_cur;
  assign nxt_plus_q  = at_plus_cur + a_q.len;
  assign at_gran     = at_ext + LW'(HEADER_GRANULES);
  assign len_ge_need  = CW'(a_q.len) >= CW'(need);
  assign len_ge_split = CW'(a_q.len) >= (CW'(need) + CW'(split_eff));

  assign in_ready = (st == S_IDLE);

  // sequencer
  always_comb begin
    st_next         = st;
    at_next         = at;
    prv_next        = prv;
    len_cur_next    = len_cur;
    need_next       = need;
    res_status_next = res_status;
    res_gran_next   = res_gran;
    a_we    = 1'b0;
    a_waddr = at;
    a_wdata = '0;
    a_raddr = at;
    p_we    = 1'b0;
    p_waddr = at;
    p_wdata = at;
    p_raddr = at;
    case (st)
      S_CLEAR: begin
        a_we    = 1'b1;
        a_waddr = clr;
        if (clr == '0) begin
          a_wdata = '{len: ARENA_LEN, used: 1'b0, mark: 1'b1};
        end
        if (clr == CLR_LAST) begin
          st_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          res_gran_next = '0;
          if (action == ACT_ALLOC) begin
            if (size_bytes == '0) begin
              res_status_next = ST_ZERO;
              st_next         = S_RESP;
            end else begin
              need_next = need_calc;
              at_next   = '0;
              a_raddr   = '0;
              st_next   = S_A_CHK;
            end
          end else begin
            if (pay_bad) begin
              res_status_next = ST_NOTUSED;
              st_next         = S_RESP;
            end else begin
              at_next = AW'(pay_off);
              a_raddr = AW'(pay_off);
              st_next = S_F_CHK;
            end
          end
        end
      end
      // first-fit walk, one chunk per cycle
      S_A_CHK: begin
        if (a_q.len == '0) begin
          res_status_next = ST_NOFIT;
          st_next         = S_RESP;
        end else if (!a_q.used && len_ge_need) begin
          if (len_ge_split) begin
            a_we    = 1'b1;
            a_waddr = AW'(at_ext + LW'(need));
            a_wdata = '{len: LW'(CW'(a_q.len) - CW'(need)), used: 1'b0, mark: 1'b1};
            p_we    = 1'b1;
            p_waddr = AW'(at_ext + LW'(need));
            p_wdata = at;
            len_cur_next = a_q.len;
            st_next = S_A_SPL;
          end else begin
            a_we    = 1'b1;
            a_wdata = '{len: a_q.len, used: 1'b1, mark: 1'b1};
            res_status_next = ST_OK;
            res_gran_next   = GRAN_W'(at_gran);
            st_next = S_RESP;
          end
        end else if (at_plus_q >= ARENA_LEN) begin
          res_status_next = ST_NOFIT;
          st_next         = S_RESP;
        end else begin
          at_next = AW'(at_plus_q);
          a_raddr = AW'(at_plus_q);
        end
      end
      // second half of a split: shrink the chosen chunk, relink the follower
      S_A_SPL: begin
        a_we    = 1'b1;
        a_wdata = '{len: LW'(need), used: 1'b1, mark: 1'b1};
        if (at_plus_cur < ARENA_LEN) begin
          p_we    = 1'b1;
          p_waddr = AW'(at_plus_cur);
          p_wdata = AW'(at_ext + LW'(need));
        end
        res_status_next = ST_OK;
        res_gran_next   = GRAN_W'(at_gran);
        st_next = S_RESP;
      end
      S_F_CHK: begin
        if (!a_q.mark || !a_q.used) begin
          res_status_next = ST_NOTUSED;
          st_next         = S_RESP;
        end else begin
          len_cur_next = a_q.len;
          if (at_plus_q < ARENA_LEN) begin
            a_raddr = AW'(at_plus_q);
            st_next = S_F_NXT;
          end else begin
            st_next = S_F_PR0;
          end
        end
      end
      // merge with a free next chunk
      S_F_NXT: begin
        if (!a_q.used) begin
          len_cur_next = len_cur + a_q.len;
          a_we    = 1'b1;
          a_waddr = AW'(at_plus_cur);
          if (nxt_plus_q < ARENA_LEN) begin
            p_we    = 1'b1;
            p_waddr = AW'(nxt_plus_q);
            p_wdata = at;
          end
        end
        st_next = S_F_PR0;
      end
      S_F_PR0: begin
        if (at == '0) begin
          a_we    = 1'b1;
          a_wdata = '{len: len_cur, used: 1'b0, mark: 1'b1};
          res_status_next = ST_OK;
          st_next = S_RESP;
        end else begin
          st_next = S_F_PR1;
        end
      end
      S_F_PR1: begin
        prv_next = p_q;
        a_raddr  = p_q;
        st_next  = S_F_PR2;
      end
      // merge into a free previous chunk
      S_F_PR2: begin
        a_we = 1'b1;
        if (!a_q.used) begin
          a_waddr = prv;
          a_wdata = '{len: a_q.len + len_cur, used: 1'b0, mark: a_q.mark};
          st_next = S_F_MRG;
        end else begin
          a_wdata = '{len: len_cur, used: 1'b0, mark: 1'b1};
          res_status_next = ST_OK;
          st_next = S_RESP;
        end
      end
      S_F_MRG: begin
        a_we = 1'b1;
        if (at_plus_cur < ARENA_LEN) begin
          p_we    = 1'b1;
          p_waddr = AW'(at_plus_cur);
          p_wdata = prv;
        end
        res_status_next = ST_OK;
        st_next = S_RESP;
      end
      S_RESP: begin
        if (!out_valid || out_ready) begin
          st_next = S_IDLE;
        end
      end
      default: begin
        st_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= S_CLEAR;
      clr <= '0;
    end else begin
      st <= st_next;
      if (st == S_CLEAR) begin
        clr <= clr + AW'(1);
      end
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    at         <= at_next;
    prv        <= prv_next;
    len_cur    <= len_cur_next;
    need       <= need_next;
    res_status <= res_status_next;
    res_gran   <= res_gran_next;
  end

  // split threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_split <= SPLIT_RESET;
    end else if (cfg_wr_en) begin
      min_split <= cfg_wr_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (st == S_RESP && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st == S_RESP && (!out_valid || out_ready)) begin
      status          <= res_status;
      granted_granule <= res_gran;
    end
  end

endmodule

/* rtl/core/ffsca_checker.sv */
module ffsca_checker
  import ffsca_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [STAT_W-1:0] status,
  input logic [GRAN_W-1:0] granted_granule
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(granted_granule))
    else $error("result changed while stalled");

  // failed or free results carry no granule
  a_err_gran: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> granted_granule == '0)
    else $error("granule set on failed result");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while busy");

  // a result is never shown in the cycle after an item is taken
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too early");

endmodule

bind first_fit_split_coalesce_allocator ffsca_checker u_ffsca_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .status          (status),
  .granted_granule (granted_granule)
);

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import ffsca_pkg::*;

  localparam int ARENA = 1024;
  localparam int HDR   = 2;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               action = ACT_ALLOC;
  logic [SIZE_W-1:0]  size_bytes = '0;
  logic [GRAN_W-1:0]  payload_granule = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [STAT_W-1:0]  status;
  logic [GRAN_W-1:0]  granted_granule;
  logic               cfg_wr_en = 1'b0;
  logic [SPLIT_W-1:0] cfg_wr_data = '0;

  first_fit_split_coalesce_allocator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .size_bytes(size_bytes), .payload_granule(payload_granule),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .granted_granule(granted_granule),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  typedef struct packed {
    logic [STAT_W-1:0] st;
    logic [GRAN_W-1:0] gran;
  } alloc_reply_t;

  // arena shadow
  int unsigned        arena_len [ARENA];
  bit                 arena_used[ARENA];
  bit                 arena_head[ARENA];
  int unsigned        arena_prev[ARENA];
  logic [SPLIT_W-1:0] split_min;

  alloc_reply_t reply_q[$];
  int unsigned  live_q[$];   // payload granules currently allocated
  int           errors = 0;
  int           n_sent = 0;
  int           n_checked = 0;
  int           n_alloc_ok = 0;
  int           n_merge = 0;
  int           long_stall = 0;
  bit           rx_gaps = 1'b1;

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $time);
  endtask

  task automatic shadow_reset();
    for (int i = 0; i < ARENA; i++) begin
      arena_len[i] = 0;
      arena_used[i] = 0;
      arena_head[i] = 0;
      arena_prev[i] = 0;
    end
    arena_len[0] = ARENA;
    arena_head[0] = 1;
    split_min = SPLIT_RESET;
  endtask

  function automatic alloc_reply_t predict_alloc(input int unsigned nbytes);
    alloc_reply_t r;
    int unsigned need, thr, at, len, rest, after, guard;
    r = '{st: ST_OK, gran: '0};
    if (nbytes == 0) begin
      r.st = ST_ZERO;
      return r;
    end
    need = ((nbytes + 15) >> GRANULE_SHIFT) + HDR;
    thr = (split_min == 0) ? 1 : split_min;
    at = 0;
    guard = 0;
    while (at < ARENA && guard < ARENA) begin
      len = arena_len[at];
      if (len == 0) break;
      if (!arena_used[at] && len >= need) begin
        if (len >= need + thr) begin
          rest = at + need;
          after = at + len;
          arena_len[rest] = len - need;
          arena_used[rest] = 0;
          arena_head[rest] = 1;
          arena_prev[rest] = at;
          if (after < ARENA) arena_prev[after] = rest;
          arena_len[at] = need;
        end
        arena_used[at] = 1;
        r.gran = GRAN_W'(at + HDR);
        live_q.push_back(at + HDR);
        n_alloc_ok++;
        return r;
      end
      at += len;
      guard++;
    end
    r.st = ST_NOFIT;
    return r;
  endfunction

  function automatic alloc_reply_t predict_free(input int unsigned pg);
    alloc_reply_t r;
    int unsigned at, nxt, prv, beyond;
    r = '{st: ST_OK, gran: '0};
    if (pg < HDR) begin
      r.st = ST_NOTUSED;
      return r;
    end
    at = pg - HDR;
    if (!arena_head[at] || !arena_used[at]) begin
      r.st = ST_NOTUSED;
      return r;
    end
    arena_used[at] = 0;
    foreach (live_q[i]) if (live_q[i] == pg) begin
      live_q.delete(i);
      break;
    end
    // merge with following free chunk
    nxt = at + arena_len[at];
    if (nxt < ARENA && !arena_used[nxt]) begin
      beyond = nxt + arena_len[nxt];
      arena_len[at] += arena_len[nxt];
      arena_len[nxt] = 0;
      arena_head[nxt] = 0;
      if (beyond < ARENA) arena_prev[beyond] = at;
      n_merge++;
    end
    // merge into preceding free chunk
    if (at != 0) begin
      prv = arena_prev[at] % ARENA;
      if (!arena_used[prv]) begin
        beyond = at + arena_len[at];
        arena_len[prv] += arena_len[at];
        arena_len[at] = 0;
        arena_head[at] = 0;
        if (beyond < ARENA) arena_prev[beyond] = prv;
        n_merge++;
      end
    end
    return r;
  endfunction

  // send one item and queue its expected reply at acceptance
  task automatic send_item(input logic act, input int unsigned nbytes, input int unsigned pg);
    @(negedge clk);
    in_valid <= 1'b1;
    action <= act;
    size_bytes <= SIZE_W'(nbytes);
    payload_granule <= GRAN_W'(pg);
    do @(posedge clk); while (!in_ready);
    if (act == ACT_ALLOC) reply_q.push_back(predict_alloc(nbytes));
    else reply_q.push_back(predict_free(pg));
    n_sent++;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic send_gap();
    int g;
    g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    repeat (g) @(negedge clk);
  endtask

  task automatic drain();
    while (reply_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_split(input int unsigned v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= SPLIT_W'(v);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    split_min = SPLIT_W'(v);
  endtask

  function automatic int unsigned pick_live();
    return live_q.size() ? live_q[$urandom_range(0, live_q.size() - 1)] : HDR;
  endfunction

  function automatic int unsigned rand_size();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 16384);
      1: return $urandom_range(0, 32767);
      default: return $urandom_range(1, 400);
    endcase
  endfunction

  // reply checker with random stalls
  always @(negedge clk) begin
    if (long_stall > 0) begin
      out_ready <= 1'b0;
      long_stall <= long_stall - 1;
    end else if (!rx_gaps) out_ready <= 1'b1;
    else if ($urandom_range(0, 29) == 0) begin
      out_ready <= 1'b0;
      long_stall <= $urandom_range(10, 50);
    end else out_ready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    alloc_reply_t e;
    if (!rst && out_valid && out_ready) begin
      if (reply_q.size() == 0) report_mismatch("unexpected reply", status, -1);
      else begin
        e = reply_q.pop_front();
        if (status !== e.st) report_mismatch("status", status, e.st);
        if (granted_granule !== e.gran) report_mismatch("granted_granule", granted_granule, e.gran);
        n_checked++;
      end
    end
  end

  task automatic test_directed();
    send_item(ACT_ALLOC, 0, 0);          // zero size
    send_item(ACT_ALLOC, 32767, 0);      // oversized
    send_item(ACT_ALLOC, 16384, 0);      // whole arena is too small once header added
    send_item(ACT_ALLOC, 1, 0);
    send_item(ACT_ALLOC, 16, 0);
    send_item(ACT_ALLOC, 17, 0);
    send_item(ACT_FREE, 0, 0);           // below header
    send_item(ACT_FREE, 0, 1);
    send_item(ACT_FREE, 0, 1023);        // not a chunk start
    send_item(ACT_FREE, 0, 5);           // middle chunk, no merge
    send_item(ACT_FREE, 0, 5);           // double free
    send_item(ACT_FREE, 0, 2);           // merges with next
    send_item(ACT_FREE, 0, 8);           // merges both ways
    send_item(ACT_ALLOC, 16320, 0);      // takes the whole arena, remainder too small to split
    send_item(ACT_ALLOC, 1, 0);
    send_item(ACT_FREE, 0, 2);
    drain();
  endtask

  task automatic test_split_settings();
    int unsigned vals[5] = '{0, 1, 64, 127, 4};
    foreach (vals[k]) begin
      write_split(vals[k]);
      repeat (12) begin
        send_item(ACT_ALLOC, rand_size(), 0);
        send_gap();
      end
      while (live_q.size()) send_item(ACT_FREE, 0, pick_live());
      drain();
    end
  endtask

  task automatic test_random(input int count);
    int unsigned r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50 || live_q.size() == 0) send_item(ACT_ALLOC, rand_size(), $urandom);
      else if (r < 90) send_item(ACT_FREE, $urandom, pick_live());
      else send_item(ACT_FREE, $urandom, $urandom_range(0, 1023));
      send_gap();
      if (i % 300 == 299) begin
        drain();
        write_split($urandom_range(0, 127));
      end
    end
    drain();
  endtask

  task automatic test_backpressure();
    long_stall = 300;
    for (int i = 0; i < 20; i++) send_item(ACT_ALLOC, $urandom_range(1, 64), 0);
    drain();
    rx_gaps = 1'b0;
    for (int i = 0; i < 30; i++) send_item(ACT_FREE, 0, pick_live());
    rx_gaps = 1'b1;
    drain();
  endtask

  initial begin
    shadow_reset();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_split_settings();
    test_backpressure();
    test_random(1100);
    $display("sent %0d items, checked %0d replies, %0d grants, %0d merges",
             n_sent, n_checked, n_alloc_ok, n_merge);
    $display("split threshold swept over 0, 1, 64, 127 and random values");
    if (errors == 0 && reply_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
